>>> rtl/rvs_pkg.sv
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types and constants for the RV32I instruction step block.
// ----------------------------------------------------------------------------
package rvs_pkg;

	// host operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_EXEC  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// fault codes
	localparam logic [1:0] FLT_NONE    = 2'd0;
	localparam logic [1:0] FLT_ILLEGAL = 2'd1;
	localparam logic [1:0] FLT_RANGE   = 2'd2;

	// opcodes
	localparam logic [6:0] OPC_MASK   = 7'h7f;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_REG    = 7'h33;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [31:0] UPPER_MASK = 32'hfffff000;

	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// memory access request
	typedef struct packed {
		logic        en;
		logic        we;
		logic [31:0] addr;
		logic [2:0]  nbytes;
		logic [31:0] wdata;
	} mem_req_t;

	// register file write
	typedef struct packed {
		logic        we;
		logic [4:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

endpackage

>>> rtl/rvs_if.sv
// ----------------------------------------------------------------------------
// rvs_if
// Request and response channels of the RV32I instruction step block.
// ----------------------------------------------------------------------------
interface rvs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] mem_address;
	logic [31:0] write_data;

	modport source (output valid, operation, mem_address, write_data, input ready);
	modport sink   (input valid, operation, mem_address, write_data, output ready);
endinterface

interface rvs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [31:0] program_counter;
	logic        halted;
	logic [31:0] exit_code;
	logic [1:0]  fault;
	logic [63:0] retired_count;

	modport source (output valid, read_data, program_counter, halted, exit_code, fault,
		retired_count, input ready);
	modport sink   (input valid, read_data, program_counter, halted, exit_code, fault,
		retired_count, output ready);
endinterface

>>> rtl/rvs_mem.sv
// ----------------------------------------------------------------------------
// rvs_mem
// Byte-addressed memory in four byte-lane banks with registered reads.
// Any 1..4 byte access, aligned or not, touches each bank at most once.
// ----------------------------------------------------------------------------
module rvs_mem
	import rvs_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    req,
	output logic [31:0] rdata,
	output logic        busy
);

	localparam int DEPTH = (MEM_BYTES + 3) / 4;
	localparam int RBITS = $clog2(DEPTH);

	logic [RBITS-1:0] clr_q;
	logic             busy_q;
	logic [1:0]       lane_q;
	wire  [7:0]       bank_data [4];
	wire              bank_en [4];

	assign busy = busy_q;

	// clearing sweep after reset, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == RBITS'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.en && !req.we) begin
			lane_q <= req.addr[1:0];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [1:0]  off;
		logic [32:0] baddr;
		logic        en;
		logic [7:0]  ram [DEPTH];
		logic [7:0]  data_q;
		logic        en_q;

		assign off   = 2'(k) - req.addr[1:0];
		assign baddr = {1'b0, req.addr} + {31'b0, off};
		assign en    = req.en && !busy_q && ({1'b0, off} < req.nbytes)
			&& (baddr < 33'(MEM_BYTES));

		always_ff @(posedge clk) begin
			if (busy_q) begin
				ram[clr_q] <= 8'h00;
			end else if (en && req.we) begin
				ram[baddr[RBITS+1:2]] <= req.wdata[{off, 3'b000} +: 8];
			end
			if (en && !req.we) begin
				data_q <= ram[baddr[RBITS+1:2]];
			end
			if (req.en && !req.we) begin
				en_q <= en;
			end
		end

		assign bank_data[k] = data_q;
		assign bank_en[k]   = en_q;
	end

	// byte i of the word comes from bank (lane + i); skipped bytes read zero
	always_comb begin
		logic [1:0] j;
		rdata = '0;
		for (int i = 0; i < 4; i++) begin
			j = lane_q + 2'(i);
			rdata[8*i +: 8] = bank_en[j] ? bank_data[j] : 8'h00;
		end
	end

endmodule

>>> rtl/rvs_regfile.sv
// ----------------------------------------------------------------------------
// rvs_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Valid bits make unwritten entries (and x0) read zero after reset.
// ----------------------------------------------------------------------------
module rvs_regfile
	import rvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rs1,
	input  logic [4:0]  rs2,
	output logic [31:0] a,
	output logic [31:0] b,
	input  rf_wr_t      wr,
	output logic [31:0] x17
);

	logic [31:0] regs [32];
	logic [31:0] valid_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] x17_q;

	assign a   = a_q;
	assign b   = b_q;
	assign x17 = x17_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			x17_q   <= '0;
		end else if (wr.we && wr.addr != 5'd0) begin
			valid_q[wr.addr] <= 1'b1;
			if (wr.addr == 5'd17) begin
				x17_q <= wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we && wr.addr != 5'd0) begin
			regs[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			a_q <= valid_q[rs1] ? regs[rs1] : 32'h0;
			b_q <= valid_q[rs2] ? regs[rs2] : 32'h0;
		end
	end

endmodule

>>> rtl/rv32i_instruction_step_top.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_step_top
// RV32I core stepped one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction: a host word write, a host word read, or
//   the execution of the instruction at the program counter. rsp returns
//   one transaction per request with the read word and the core state
//   (pc, halt status, exit code, fault, retired count) after it.
//   From request accept to response: host write, unused code or blocked
//     execute go straight to the response state, host read through the
//     memory read, execute through fetch and execute, a load also load data.
//   The next request is taken in the cycle after the response is loaded.
//   Execute walks fetch, register read, execute and optional load data
//   through the byte-lane memory, whose reads are registered.
//   Reset clears registers and state at once; the memory is then swept to
//   zero, one row of four bytes per cycle, all MEM_BYTES/4 rows (rounded up),
//   while req.ready stays low.
//   A stalled response holds in the output register; the block finishes
//   the pending transaction and waits before taking another request.
// ----------------------------------------------------------------------------
module rv32i_instruction_step_top
	import rvs_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	rvs_req_if.sink    req,
	rvs_rsp_if.source  rsp
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HREAD = 6'b000010,
		S_FETCH = 6'b000100,
		S_EXEC  = 6'b001000,
		S_LOAD  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t      state_q, state_d;
	logic [31:0] pc_q;
	logic [63:0] retired_q;
	logic        halt_q;
	logic [31:0] hcode_q;
	logic [1:0]  fault_q;
	logic [31:0] rdata_q;
	logic [31:0] instr_q;

	logic        ov_q;
	logic [31:0] o_rdata_q, o_pc_q, o_exit_q;
	logic        o_halt_q;
	logic [1:0]  o_fault_q;
	logic [63:0] o_ret_q;

	mem_req_t    mreq;
	logic [31:0] mrdata;
	logic        mbusy;
	rf_wr_t      rfw;
	logic [31:0] ra, rb, x17;
	logic        accept, out_free, fetch_ok;

	rvs_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mrdata),
		.busy   (mbusy)
	);

	rvs_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (state_q == S_FETCH),
		.rs1    (mrdata[19:15]),
		.rs2    (mrdata[24:20]),
		.a      (ra),
		.b      (rb),
		.wr     (rfw),
		.x17    (x17)
	);

	assign req.ready = (state_q == S_IDLE) && !mbusy;
	assign accept    = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;
	assign fetch_ok  = ({1'b0, pc_q} + 33'd4) <= 33'(MEM_BYTES);

	// ---------------- decode and execute ----------------
	logic [6:0]  opc, f7;
	logic [4:0]  rd, shamt;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4;
	logic [31:0] ex_res, ex_npc, ex_addr;
	logic        ex_wr, ex_halt, ex_ecall, ex_load, ex_store;
	logic [1:0]  ex_fault;
	logic [2:0]  ex_n;
	logic        ex_inr, take;
	logic [4:0]  rshift;
	logic [31:0] ld_res;

	assign opc    = instr_q[6:0] & OPC_MASK;
	assign rd     = instr_q[11:7];
	assign f3     = instr_q[14:12];
	assign shamt  = instr_q[24:20];
	assign f7     = instr_q[31:25];
	assign imm_i  = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imm_s  = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign imm_b  = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign imm_u  = instr_q & UPPER_MASK;
	assign imm_j  = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};
	assign pc4    = pc_q + 32'd4;
	assign rshift = rb[4:0];
	assign ex_inr = ({1'b0, ex_addr} + {30'b0, ex_n}) <= 33'(MEM_BYTES);

	always_comb begin
		ex_res   = '0;
		ex_npc   = pc4;
		ex_addr  = ra + imm_i;
		ex_wr    = 1'b0;
		ex_halt  = 1'b0;
		ex_ecall = 1'b0;
		ex_fault = FLT_NONE;
		ex_load  = 1'b0;
		ex_store = 1'b0;
		ex_n     = 3'd0;
		take     = 1'b0;
		unique case (opc)
			OPC_LUI: begin
				ex_res = imm_u;
				ex_wr  = 1'b1;
			end
			OPC_AUIPC: begin
				ex_res = pc_q + imm_u;
				ex_wr  = 1'b1;
			end
			OPC_JAL: begin
				ex_res = pc4;
				ex_wr  = 1'b1;
				ex_npc = pc_q + imm_j;
			end
			OPC_JALR: begin
				ex_res = pc4;
				ex_wr  = 1'b1;
				ex_npc = (ra + imm_i) & ~32'd1;
			end
			OPC_BRANCH: begin
				unique case (f3)
					3'd0:    take = ra == rb;
					3'd1:    take = ra != rb;
					3'd4:    take = $signed(ra) < $signed(rb);
					3'd5:    take = !($signed(ra) < $signed(rb));
					3'd6:    take = ra < rb;
					3'd7:    take = ra >= rb;
					default: take = 1'b0;
				endcase
				if (take) begin
					ex_npc = pc_q + imm_b;
				end
			end
			OPC_LOAD: begin
				unique case (f3)
					3'd0, 3'd4: ex_n = 3'd1;
					3'd1, 3'd5: ex_n = 3'd2;
					3'd2:       ex_n = 3'd4;
					default:    ex_n = 3'd0;
				endcase
				if (ex_n != 3'd0) begin
					if (ex_inr) begin
						ex_load = 1'b1;
					end else begin
						ex_halt  = 1'b1;
						ex_fault = FLT_RANGE;
					end
				end
			end
			OPC_STORE: begin
				ex_addr = ra + imm_s;
				unique case (f3)
					3'd0:    ex_n = 3'd1;
					3'd1:    ex_n = 3'd2;
					3'd2:    ex_n = 3'd4;
					default: ex_n = 3'd0;
				endcase
				if (ex_n != 3'd0) begin
					if (ex_inr) begin
						ex_store = 1'b1;
					end else begin
						ex_halt  = 1'b1;
						ex_fault = FLT_RANGE;
					end
				end
			end
			OPC_IMM: begin
				ex_wr = 1'b1;
				unique case (f3)
					3'd0: ex_res = ra + imm_i;
					3'd2: ex_res = {31'b0, $signed(ra) < $signed(imm_i)};
					3'd3: ex_res = {31'b0, ra < imm_i};
					3'd4: ex_res = ra ^ imm_i;
					3'd6: ex_res = ra | imm_i;
					3'd7: ex_res = ra & imm_i;
					3'd1: begin
						if (f7 == F7_ZERO) ex_res = ra << shamt;
						else ex_wr = 1'b0;
					end
					default: begin
						if (f7 == F7_ZERO) ex_res = ra >> shamt;
						else if (f7 == F7_ALT) ex_res = 32'($signed(ra) >>> shamt);
						else ex_wr = 1'b0;
					end
				endcase
			end
			OPC_REG: begin
				ex_wr = 1'b1;
				priority if (f7 == F7_ZERO) begin
					unique case (f3)
						3'd0: ex_res = ra + rb;
						3'd1: ex_res = ra << rshift;
						3'd2: ex_res = {31'b0, $signed(ra) < $signed(rb)};
						3'd3: ex_res = {31'b0, ra < rb};
						3'd4: ex_res = ra ^ rb;
						3'd5: ex_res = ra >> rshift;
						3'd6: ex_res = ra | rb;
						default: ex_res = ra & rb;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					ex_res = ra - rb;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					ex_res = 32'($signed(ra) >>> rshift);
				end else begin
					ex_wr = 1'b0;
				end
			end
			OPC_FENCE: begin
			end
			OPC_SYSTEM: begin
				ex_halt = 1'b1;
				if (instr_q[31:20] == 12'd0) begin
					ex_ecall = 1'b1;
				end else begin
					ex_fault = FLT_ILLEGAL;
				end
			end
			default: begin
				ex_halt  = 1'b1;
				ex_fault = FLT_ILLEGAL;
			end
		endcase
	end

	// load data extension
	always_comb begin
		unique case (f3)
			3'd0:    ld_res = {{24{mrdata[7]}}, mrdata[7:0]};
			3'd1:    ld_res = {{16{mrdata[15]}}, mrdata[15:0]};
			default: ld_res = mrdata;
		endcase
	end

	// ---------------- memory and register file requests ----------------
	always_comb begin
		mreq = '0;
		rfw  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.operation == OP_WRITE) begin
					mreq.en     = 1'b1;
					mreq.we     = 1'b1;
					mreq.addr   = {16'b0, req.mem_address};
					mreq.nbytes = 3'd4;
					mreq.wdata  = req.write_data;
				end else if (accept && req.operation == OP_READ) begin
					mreq.en     = 1'b1;
					mreq.addr   = {16'b0, req.mem_address};
					mreq.nbytes = 3'd4;
				end else if (accept && req.operation == OP_EXEC && !halt_q && fetch_ok) begin
					mreq.en     = 1'b1;
					mreq.addr   = pc_q;
					mreq.nbytes = 3'd4;
				end
			end
			S_EXEC: begin
				mreq.en     = ex_load || ex_store;
				mreq.we     = ex_store;
				mreq.addr   = ex_addr;
				mreq.nbytes = ex_n;
				mreq.wdata  = rb;
				rfw.we      = ex_wr;
				rfw.addr    = rd;
				rfw.data    = ex_res;
			end
			S_LOAD: begin
				rfw.we   = 1'b1;
				rfw.addr = rd;
				rfw.data = ld_res;
			end
			default: begin
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.operation == OP_READ) begin
						state_d = S_HREAD;
					end else if (req.operation == OP_EXEC && !halt_q && fetch_ok) begin
						state_d = S_FETCH;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_HREAD: state_d = S_RESP;
			S_FETCH: state_d = S_EXEC;
			S_EXEC:  state_d = ex_load ? S_LOAD : S_RESP;
			S_LOAD:  state_d = S_RESP;
			S_RESP:  state_d = out_free ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			retired_q <= '0;
			halt_q    <= 1'b0;
			hcode_q   <= '0;
			fault_q   <= FLT_NONE;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept && req.operation == OP_EXEC
				&& !halt_q && !fetch_ok) begin
				halt_q  <= 1'b1;
				fault_q <= FLT_RANGE;
			end
			if (state_q == S_EXEC) begin
				retired_q <= retired_q + 64'd1;
				pc_q      <= ex_npc;
				if (ex_halt) begin
					halt_q  <= 1'b1;
					fault_q <= ex_fault;
				end
				if (ex_ecall) begin
					hcode_q <= x17;
				end
			end
			if (state_q == S_RESP && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= '0;
		end
		if (state_q == S_HREAD) begin
			rdata_q <= mrdata;
		end
		if (state_q == S_FETCH) begin
			instr_q <= mrdata;
		end
		if (state_q == S_RESP && out_free) begin
			o_rdata_q <= rdata_q;
			o_pc_q    <= pc_q;
			o_halt_q  <= halt_q;
			o_exit_q  <= hcode_q;
			o_fault_q <= fault_q;
			o_ret_q   <= retired_q;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.read_data       = o_rdata_q;
	assign rsp.program_counter = o_pc_q;
	assign rsp.halted          = o_halt_q;
	assign rsp.exit_code       = o_exit_q;
	assign rsp.fault           = o_fault_q;
	assign rsp.retired_count   = o_ret_q;

endmodule

>>> rtl/rvs_checker.sv
// ----------------------------------------------------------------------------
// rvs_checker
// Port-level checks for the RV32I instruction step block.
// ----------------------------------------------------------------------------
module rvs_checker
	import rvs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_halted,
	input logic [1:0]  rsp_fault,
	input logic [63:0] rsp_retired
);

	logic        fire;
	logic        seen_halt_q;
	logic [63:0] last_ret_q;

	assign fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
			last_ret_q  <= '0;
		end else if (fire) begin
			seen_halt_q <= seen_halt_q || rsp_halted;
			last_ret_q  <= rsp_retired;
		end
	end

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_retired))
		else $error("response changed while stalled");

	// a fault always comes with halt
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fault != FLT_NONE |-> rsp_halted)
		else $error("fault reported without halt");

	// halt is sticky across transactions
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && seen_halt_q |-> rsp_halted)
		else $error("halt cleared");

	// nothing retires after halt
	a_ret_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		fire && seen_halt_q |-> rsp_retired == last_ret_q)
		else $error("instruction retired after halt");

endmodule

bind rv32i_instruction_step_top rvs_checker u_rvs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_halted  (rsp.halted),
	.rsp_fault   (rsp.fault),
	.rsp_retired (rsp.retired_count)
);
